### src/phfh_pkg.sv
`default_nettype none
// Shared types and constants for the packet header field histogram.
// No dependencies; every other file of the block imports this package.
package phfh_pkg;

  // Table geometry and counter width defaults
  localparam int SMALL_DEPTH_DEF = 256;
  localparam int LARGE_DEPTH_DEF = 65536;
  localparam int COUNTER_WIDTH_DEF = 64;
  localparam int SMALL_AW = 8;
  localparam int LARGE_AW = 16;
  localparam int VALUE_WIDTH = 64;

  // Header layout, in byte positions from the Ethernet destination
  localparam logic [6:0] POS_ETYPE_HI = 7'd12;
  localparam logic [6:0] POS_ETYPE_LO = 7'd13;
  localparam logic [6:0] POS_VER_IHL = 7'd14;
  localparam logic [6:0] POS_TLEN_HI = 7'd16;
  localparam logic [6:0] POS_TLEN_LO = 7'd17;
  localparam logic [6:0] POS_IDENT_HI = 7'd18;
  localparam logic [6:0] POS_IDENT_LO = 7'd19;
  localparam logic [6:0] POS_PROTO = 7'd23;
  localparam logic [6:0] POS_MAX = 7'd127;
  localparam logic [6:0] ICMP_BASE = 7'd22;   // Ethernet header plus ICMP offset
  localparam logic [7:0] PROTO_ICMP = 8'd1;

  // Item kinds
  typedef enum logic {
    ACT_FRAME = 1'b0,
    ACT_READ  = 1'b1
  } action_t;

  // Histogram selectors
  typedef enum logic [2:0] {
    TBL_PROTO   = 3'd0,
    TBL_ETYPE   = 3'd1,
    TBL_IDENT   = 3'd2,
    TBL_VER_IHL = 3'd3,
    TBL_TLEN    = 3'd4,
    TBL_ICMP    = 3'd5
  } table_sel_t;

  // Increment request from the header parser to the tables
  typedef struct packed {
    logic                bump;
    logic [SMALL_AW-1:0] proto;
    logic [LARGE_AW-1:0] ether_type;
    logic [LARGE_AW-1:0] ident;
    logic [SMALL_AW-1:0] ver_ihl;
    logic [LARGE_AW-1:0] total_length;
    logic [SMALL_AW-1:0] icmp_byte;
  } bump_req_t;

endpackage
`default_nettype wire

### src/phfh_capture.sv
`default_nettype none
// Header parser: tracks byte position, captures the header fields and
// raises an increment request on the last byte of a complete outgoing frame.
// Depends on phfh_pkg.
module phfh_capture (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              byte_take,
  input  wire logic [7:0]        frame_byte,
  input  wire logic              frame_last,
  input  wire logic              outgoing_packet,
  output phfh_pkg::bump_req_t    req
);
  import phfh_pkg::*;

  logic [6:0]  pos;
  logic [15:0] ether_type, ether_type_next;
  logic [7:0]  ver_ihl, ver_ihl_next;
  logic [15:0] total_length, total_length_next;
  logic [15:0] ident, ident_next;
  logic [7:0]  proto, proto_next;
  logic [7:0]  icmp_byte, icmp_byte_next;
  logic        icmp_seen, icmp_seen_next;
  logic [6:0]  icmp_pos;
  logic        is_icmp;
  logic        complete;

  // Locate the ICMP byte from the IHL captured earlier in this frame
  assign icmp_pos = ICMP_BASE + {1'b0, ver_ihl[3:0], 2'b00};

  // Merge the current byte into the captured fields
  always_comb begin
    ether_type_next   = ether_type;
    ver_ihl_next      = ver_ihl;
    total_length_next = total_length;
    ident_next        = ident;
    proto_next        = proto;
    icmp_byte_next    = icmp_byte;
    icmp_seen_next    = icmp_seen;
    case (pos)
      POS_ETYPE_HI: ether_type_next[15:8] = frame_byte;
      POS_ETYPE_LO: ether_type_next[7:0] = frame_byte;
      POS_VER_IHL:  ver_ihl_next = frame_byte;
      POS_TLEN_HI:  total_length_next[15:8] = frame_byte;
      POS_TLEN_LO:  total_length_next[7:0] = frame_byte;
      POS_IDENT_HI: ident_next[15:8] = frame_byte;
      POS_IDENT_LO: ident_next[7:0] = frame_byte;
      POS_PROTO:    proto_next = frame_byte;
      default: ;
    endcase
    if (pos > POS_VER_IHL && pos == icmp_pos) begin
      icmp_byte_next = frame_byte;
      icmp_seen_next = 1'b1;
    end
  end

  // Decide whether the frame ending here is counted
  assign is_icmp  = (proto_next == PROTO_ICMP);
  assign complete = (pos >= POS_PROTO) && (!is_icmp || icmp_seen_next);

  always_comb begin
    req.bump         = byte_take && frame_last && outgoing_packet && complete;
    req.proto        = proto_next;
    req.ether_type   = ether_type_next;
    req.ident        = ident_next;
    req.ver_ihl      = ver_ihl_next;
    req.total_length = total_length_next;
    req.icmp_byte    = is_icmp ? icmp_byte_next : '0;
  end

  // Advance position and hold captures on every accepted frame byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      ether_type   <= '0;
      ver_ihl      <= '0;
      total_length <= '0;
      ident        <= '0;
      proto        <= '0;
      icmp_byte    <= '0;
      icmp_seen    <= 1'b0;
    end else if (byte_take) begin
      ether_type   <= ether_type_next;
      ver_ihl      <= ver_ihl_next;
      total_length <= total_length_next;
      ident        <= ident_next;
      proto        <= proto_next;
      icmp_byte    <= icmp_byte_next;
      if (frame_last) begin
        pos       <= '0;
        icmp_seen <= 1'b0;
      end else begin
        icmp_seen <= icmp_seen_next;
        if (pos < POS_MAX) begin
          pos <= pos + 7'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### src/phfh_hist_mem.sv
`default_nettype none
// One histogram table: synchronous RAM with read-increment-write and
// forwarding of the write that lands on the same edge as a read.
// Depends on phfh_pkg.
module phfh_hist_mem #(
  parameter int DEPTH = phfh_pkg::SMALL_DEPTH_DEF,
  parameter int WIDTH = phfh_pkg::COUNTER_WIDTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             clr_en,
  input  wire logic [AW-1:0]    clr_addr,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  input  wire logic             inc_en,
  output logic      [WIDTH-1:0] rd_data
);
  import phfh_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] ram_q;
  logic             inc_pend;
  logic [AW-1:0]    inc_addr;
  logic             fwd_hit;
  logic [WIDTH-1:0] fwd_data;
  logic [WIDTH-1:0] sum;

  // Take the value written on the read edge in place of the stale RAM word
  assign rd_data = fwd_hit ? fwd_data : ram_q;
  assign sum     = rd_data + WIDTH'(1);

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      ram_q    <= mem[rd_addr];
      fwd_data <= sum;
    end
  end

  // Write port: clearing sweep, or else the pending increment
  always_ff @(posedge clk) begin
    if (clr_en) begin
      mem[clr_addr] <= '0;
    end else if (inc_pend) begin
      mem[inc_addr] <= sum;
    end
  end

  // Track the pending increment and the forward condition
  always_ff @(posedge clk) begin
    if (rst) begin
      inc_pend <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      inc_pend <= rd_en && inc_en;
      if (rd_en) begin
        fwd_hit <= inc_pend && (inc_addr == rd_addr);
      end
    end
    if (rd_en) begin
      inc_addr <= rd_addr;
    end
  end

endmodule
`default_nettype wire

### src/packet_header_field_histogram_top.sv
`default_nettype none
// Packet header field histogram, top level: header parser, six histogram
// tables, read stage and result register. Depends on phfh_pkg,
// phfh_capture and phfh_hist_mem.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+---------------------------------
//   item     | item_valid / item_stall   | action, frame_byte, frame_last,
//            |                           | outgoing_packet, table_select,
//            |                           | read_index
//   result   | result_valid / result_stall | counter_value, index_out_of_range
//
// One item is taken per cycle while item_stall is low. A read item passes the
// registered RAM read and then the result register before its result shows.
// Frame bytes give no result; a counted frame increments all six tables in the
// cycle after its last byte, with forwarding for a read that follows at once.
// After reset a clearing pass zeroes every table, one entry per cycle, with
// item_stall high. A stalled result holds one read in the read stage and
// stalls the item side.
module packet_header_field_histogram_top #(
  parameter int SMALL_TABLE_DEPTH = phfh_pkg::SMALL_DEPTH_DEF,
  parameter int LARGE_TABLE_DEPTH = phfh_pkg::LARGE_DEPTH_DEF,
  parameter int COUNTER_WIDTH     = phfh_pkg::COUNTER_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic        action,
  input  wire logic [7:0]  frame_byte,
  input  wire logic        frame_last,
  input  wire logic        outgoing_packet,
  input  wire logic [2:0]  table_select,
  input  wire logic [15:0] read_index,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [63:0]      counter_value,
  output logic             index_out_of_range
);
  import phfh_pkg::*;

  localparam int SAW = $clog2(SMALL_TABLE_DEPTH);
  localparam int LAW = $clog2(LARGE_TABLE_DEPTH);

  logic              take;
  logic              byte_take;
  logic              is_read;
  logic              clr_busy;
  logic [LAW-1:0]    clr_addr;
  bump_req_t         req;
  logic              sel_small;
  logic              sel_large;
  logic              oor;

  logic              s1_valid;
  logic [2:0]        s1_sel;
  logic              s1_oor;
  logic              s1_hold;
  logic [COUNTER_WIDTH-1:0] s1_data;

  logic [COUNTER_WIDTH-1:0] d_proto, d_etype, d_ident, d_ver, d_tlen, d_icmp;

  // Transfer and stall
  assign s1_hold    = s1_valid && result_valid && result_stall;
  assign item_stall = clr_busy || s1_hold;
  assign take       = item_valid && !item_stall;
  assign is_read    = (action == ACT_READ);
  assign byte_take  = take && !is_read;

  // Sweep all tables once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + LAW'(1);
      if (clr_addr == '1) begin
        clr_busy <= 1'b0;
      end
    end
  end

  phfh_capture u_capture (
    .clk             (clk),
    .rst             (rst),
    .byte_take       (byte_take),
    .frame_byte      (frame_byte),
    .frame_last      (frame_last),
    .outgoing_packet (outgoing_packet),
    .req             (req)
  );

  // Tables; a read item reads read_index, a counted frame reads its fields
  phfh_hist_mem #(.DEPTH(SMALL_TABLE_DEPTH), .WIDTH(COUNTER_WIDTH)) u_proto (
    .clk(clk), .rst(rst), .clr_en(clr_busy), .clr_addr(clr_addr[SAW-1:0]),
    .rd_en(take), .rd_addr(is_read ? SAW'(read_index) : SAW'(req.proto)),
    .inc_en(req.bump), .rd_data(d_proto)
  );
  phfh_hist_mem #(.DEPTH(LARGE_TABLE_DEPTH), .WIDTH(COUNTER_WIDTH)) u_etype (
    .clk(clk), .rst(rst), .clr_en(clr_busy), .clr_addr(clr_addr),
    .rd_en(take), .rd_addr(is_read ? LAW'(read_index) : LAW'(req.ether_type)),
    .inc_en(req.bump), .rd_data(d_etype)
  );
  phfh_hist_mem #(.DEPTH(LARGE_TABLE_DEPTH), .WIDTH(COUNTER_WIDTH)) u_ident (
    .clk(clk), .rst(rst), .clr_en(clr_busy), .clr_addr(clr_addr),
    .rd_en(take), .rd_addr(is_read ? LAW'(read_index) : LAW'(req.ident)),
    .inc_en(req.bump), .rd_data(d_ident)
  );
  phfh_hist_mem #(.DEPTH(SMALL_TABLE_DEPTH), .WIDTH(COUNTER_WIDTH)) u_ver (
    .clk(clk), .rst(rst), .clr_en(clr_busy), .clr_addr(clr_addr[SAW-1:0]),
    .rd_en(take), .rd_addr(is_read ? SAW'(read_index) : SAW'(req.ver_ihl)),
    .inc_en(req.bump), .rd_data(d_ver)
  );
  phfh_hist_mem #(.DEPTH(LARGE_TABLE_DEPTH), .WIDTH(COUNTER_WIDTH)) u_tlen (
    .clk(clk), .rst(rst), .clr_en(clr_busy), .clr_addr(clr_addr),
    .rd_en(take), .rd_addr(is_read ? LAW'(read_index) : LAW'(req.total_length)),
    .inc_en(req.bump), .rd_data(d_tlen)
  );
  phfh_hist_mem #(.DEPTH(SMALL_TABLE_DEPTH), .WIDTH(COUNTER_WIDTH)) u_icmp (
    .clk(clk), .rst(rst), .clr_en(clr_busy), .clr_addr(clr_addr[SAW-1:0]),
    .rd_en(take), .rd_addr(is_read ? SAW'(read_index) : SAW'(req.icmp_byte)),
    .inc_en(req.bump), .rd_data(d_icmp)
  );

  // Range check on the read request
  assign sel_small = (table_select == TBL_PROTO) || (table_select == TBL_VER_IHL) ||
                     (table_select == TBL_ICMP);
  assign sel_large = (table_select == TBL_ETYPE) || (table_select == TBL_IDENT) ||
                     (table_select == TBL_TLEN);
  assign oor = !(sel_small || sel_large) ||
               (sel_small && (32'(read_index) >= 32'(SMALL_TABLE_DEPTH))) ||
               (sel_large && (32'(read_index) >= 32'(LARGE_TABLE_DEPTH)));

  // Read stage: hold while the result register is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_hold) begin
      s1_valid <= take && is_read;
    end
    if (take) begin
      s1_sel <= table_select;
      s1_oor <= oor;
    end
  end

  // Pick the selected table's word
  always_comb begin
    case (s1_sel)
      TBL_PROTO:   s1_data = d_proto;
      TBL_ETYPE:   s1_data = d_etype;
      TBL_IDENT:   s1_data = d_ident;
      TBL_VER_IHL: s1_data = d_ver;
      TBL_TLEN:    s1_data = d_tlen;
      TBL_ICMP:    s1_data = d_icmp;
      default:     s1_data = '0;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= s1_valid;
    end
    if (s1_valid && (!result_valid || !result_stall)) begin
      counter_value      <= s1_oor ? '0 : VALUE_WIDTH'(s1_data);
      index_out_of_range <= s1_oor;
    end
  end

`ifndef NO_ASSERTIONS
  // No result can appear while the tables are being cleared
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !result_valid && !s1_valid)
    else $error("result during clearing pass");

  // An out-of-range result always carries a zero count
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && index_out_of_range |-> counter_value == '0)
    else $error("out-of-range read returned nonzero count");

  // A held read stays in the read stage with its selector unchanged
  a_hold_keeps: assert property (@(posedge clk) disable iff (rst)
    s1_hold |=> s1_valid && $stable(s1_sel) && $stable(s1_oor))
    else $error("read stage lost a held read");

  // A held read blocks the item side
  a_hold_stalls: assert property (@(posedge clk) disable iff (rst)
    s1_hold |-> item_stall)
    else $error("item taken while read stage held");
`endif

endmodule
`default_nettype wire
